// File: src/assert_macros.svh
// assertion macros shared by the edge magnitude rtl
// no dependencies; included by modules that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, disabled while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant, same clocking and reset handling
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: src/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies; imported by every module of the block except sem_ram
`default_nettype none

package sem_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int LEVEL_W     = 3;

    localparam int SAMPLE_W  = 8;
    localparam int ROW_OUT_W = 11;
    localparam int COL_OUT_W = 11;
    localparam int CH_OUT_W  = 2;
    localparam int CFG_W     = 12;
    localparam int CHCFG_W   = 3;

    // register indexes on paddr[3:2]
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [11:0] WIDTH_RESET    = 12'd640;
    localparam logic [11:0] HEIGHT_RESET   = 12'd480;
    localparam logic [2:0]  CHANNELS_RESET = 3'd1;

    // 255.5^2 rounded down: anything above saturates
    localparam logic [20:0] SAT_LIMIT = 21'd65280;
    localparam logic [7:0]  MAG_MAX   = 8'd255;
    localparam logic [15:0] ROOT_FIRST_BIT = 16'h4000;

    // [column: left, centre, right][row: top, middle, bottom]
    typedef logic [2:0][2:0][SAMPLE_W-1:0] window_t;

    typedef struct packed {
        window_t                win;
        logic [ROW_OUT_W-1:0]   row;
        logic [COL_OUT_W-1:0]   col;
        logic [CH_OUT_W-1:0]    chan;
        logic                   last;
    } job_t;

endpackage

`default_nettype wire

// File: src/sem_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/sem_queue.sv
// short job queue between the window front end and the magnitude unit
// depends on sem_pkg
`default_nettype none

module sem_queue import sem_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  job_t               push_data,
    input  logic               pop,
    output job_t               pop_data,
    output logic               empty,
    output logic [LEVEL_W-1:0] level
);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                level_reg <= level_reg + LEVEL_W'(1);
            end
            else if (!push && do_pop)
            begin
                level_reg <= level_reg - LEVEL_W'(1);
            end
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

endmodule

`default_nettype wire

// File: src/sem_front.sv
// front end: raster position tracking, two line stores and per-channel 3x3 windows
// depends on sem_pkg, sem_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sem_front import sem_pkg::*; #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic [XW-1:0]       w_last,
    input  logic [RW-1:0]       h_last,
    input  logic [CW-1:0]       nc_last,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                full,
    input  logic [LEVEL_W-1:0]  q_level,
    output logic                q_push,
    output job_t                q_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS);

    logic [XW-1:0] x_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [AW-1:0] addr_reg;
    logic [XW-1:0] x_next;
    logic [RW-1:0] r_next;
    logic [CW-1:0] c_next;
    logic [AW-1:0] addr_next;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [XW-1:0]       s1_x_reg;
    logic [RW-1:0]       s1_r_reg;
    logic [CW-1:0]       s1_c_reg;

    window_t win_reg [MAX_CHANNELS];
    window_t win_cur;
    window_t win_next;

    logic [SAMPLE_W-1:0] top_rd;
    logic [SAMPLE_W-1:0] mid_rd;
    logic [LEVEL_W:0]    pending;
    logic                accept;

    // an item in the line-store stage may push into the queue before q_level shows it
    assign pending = {1'b0, q_level} + (LEVEL_W + 1)'(s1_valid_reg);
    assign full    = (pending >= (LEVEL_W + 1)'(QUEUE_DEPTH));
    assign accept  = push && !full;

    always_comb
    begin
        x_next    = x_reg;
        r_next    = r_reg;
        c_next    = c_reg + CW'(1);
        addr_next = addr_reg + AW'(1);
        if (c_reg == nc_last)
        begin
            c_next = '0;
            if (x_reg == w_last)
            begin
                x_next    = '0;
                addr_next = '0;
                r_next    = (r_reg == h_last) ? '0 : r_reg + RW'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            addr_reg     <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            if (restart)
            begin
                x_reg    <= '0;
                r_reg    <= '0;
                c_reg    <= '0;
                addr_reg <= '0;
            end
            else if (accept)
            begin
                x_reg    <= x_next;
                r_reg    <= r_next;
                c_reg    <= c_next;
                addr_reg <= addr_next;
            end
            if (s1_valid_reg)
            begin
                win_reg[s1_c_reg] <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_addr_reg   <= addr_reg;
            s1_x_reg      <= x_reg;
            s1_r_reg      <= r_reg;
            s1_c_reg      <= c_reg;
        end
    end

    // upper store takes the old middle row, middle store takes the new sample
    sem_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH * MAX_CHANNELS)
    ) u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (mid_rd),
        .raddr (addr_reg),
        .rdata (top_rd)
    );

    sem_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH * MAX_CHANNELS)
    ) u_middle (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_sample_reg),
        .raddr (addr_reg),
        .rdata (mid_rd)
    );

    always_comb
    begin
        win_cur        = win_reg[s1_c_reg];
        win_next[0]    = win_cur[1];
        win_next[1]    = win_cur[2];
        win_next[2][0] = top_rd;
        win_next[2][1] = mid_rd;
        win_next[2][2] = s1_sample_reg;
    end

    assign q_push      = s1_valid_reg && (s1_r_reg >= RW'(2)) && (s1_x_reg >= XW'(2));
    assign q_data.win  = win_next;
    assign q_data.row  = ROW_OUT_W'(s1_r_reg - RW'(1));
    assign q_data.col  = COL_OUT_W'(s1_x_reg - XW'(1));
    assign q_data.chan = CH_OUT_W'(s1_c_reg);
    assign q_data.last = (s1_r_reg == h_last) && (s1_x_reg == w_last) && (s1_c_reg == nc_last);

    `ASSERT_PROP(a_queue_room, clk, rst_n, q_push |-> (q_level < LEVEL_W'(QUEUE_DEPTH)), "job queue overflow")
    `ASSERT_PROP(a_addr_wrap, clk, rst_n, (accept && c_reg == nc_last && x_reg == w_last) |=> (addr_reg == '0), "line store address did not wrap at row end")
    `ASSERT_ALWAYS(a_col_range, clk, rst_n, x_reg <= w_last, "column position beyond row width")

endmodule

`default_nettype wire

// File: src/sem_back.sv
// back end: gradient, squares, bit-serial square root, rounding and result register
// depends on sem_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sem_back import sem_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  job_t                 q_data,
    output logic                 q_pop,
    output logic [ROW_OUT_W-1:0] centre_row,
    output logic [COL_OUT_W-1:0] centre_col,
    output logic [CH_OUT_W-1:0]  channel,
    output logic [7:0]           magnitude,
    output logic                 frame_last,
    output logic                 empty,
    input  logic                 pop
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [9:0]  ax_reg;
    logic [9:0]  ay_reg;
    logic [19:0] sqx_reg;
    logic [19:0] sqy_reg;
    logic        sat_reg;
    logic [15:0] rem_reg;
    logic [15:0] res_reg;
    logic [15:0] bit_reg;

    logic [ROW_OUT_W-1:0] row_reg;
    logic [COL_OUT_W-1:0] col_reg;
    logic [CH_OUT_W-1:0]  chan_reg;
    logic                 last_reg;

    logic                 out_valid_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [CH_OUT_W-1:0]  out_chan_reg;
    logic [7:0]           out_mag_reg;
    logic                 out_last_reg;

    window_t     w;
    logic [10:0] gx_pos;
    logic [10:0] gx_neg;
    logic [10:0] gy_pos;
    logic [10:0] gy_neg;
    logic [11:0] gx_diff;
    logic [11:0] gy_diff;
    logic [9:0]  ax_next;
    logic [9:0]  ay_next;
    logic [20:0] sum_next;
    logic [16:0] trial;
    logic        take;
    logic [15:0] rem_next;
    logic [15:0] res_next;
    logic [7:0]  mag_next;

    always_comb
    begin
        w       = q_data.win;
        gx_pos  = 11'(w[2][0]) + {2'b00, w[2][1], 1'b0} + 11'(w[2][2]);
        gx_neg  = 11'(w[0][0]) + {2'b00, w[0][1], 1'b0} + 11'(w[0][2]);
        gy_pos  = 11'(w[0][2]) + {2'b00, w[1][2], 1'b0} + 11'(w[2][2]);
        gy_neg  = 11'(w[0][0]) + {2'b00, w[1][0], 1'b0} + 11'(w[2][0]);
        gx_diff = {1'b0, gx_pos} - {1'b0, gx_neg};
        gy_diff = {1'b0, gy_pos} - {1'b0, gy_neg};
        ax_next = gx_diff[11] ? 10'(12'd0 - gx_diff) : gx_diff[9:0];
        ay_next = gy_diff[11] ? 10'(12'd0 - gy_diff) : gy_diff[9:0];
    end

    assign sum_next = 21'(sqx_reg) + 21'(sqy_reg);

    // one restoring square-root step per cycle
    always_comb
    begin
        trial    = 17'(res_reg) + 17'(bit_reg);
        take     = {1'b0, rem_reg} >= trial;
        rem_next = take ? rem_reg - trial[15:0] : rem_reg;
        res_next = take ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    end

    // remainder above the root means the true root is past the half point
    assign mag_next = sat_reg ? MAG_MAX : 8'(res_reg + 16'(rem_reg > res_reg));

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ax_reg   <= ax_next;
                ay_reg   <= ay_next;
                row_reg  <= q_data.row;
                col_reg  <= q_data.col;
                chan_reg <= q_data.chan;
                last_reg <= q_data.last;
            end
            S_SQUARE:
            begin
                sqx_reg <= 20'(ax_reg) * 20'(ax_reg);
                sqy_reg <= 20'(ay_reg) * 20'(ay_reg);
            end
            S_SUM:
            begin
                sat_reg <= sum_next > SAT_LIMIT;
                rem_reg <= sum_next[15:0];
                res_reg <= '0;
                bit_reg <= ROOT_FIRST_BIT;
            end
            S_ROOT:
            begin
                rem_reg <= rem_next;
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_row_reg  <= row_reg;
                    out_col_reg  <= col_reg;
                    out_chan_reg <= chan_reg;
                    out_mag_reg  <= mag_next;
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign centre_row = out_row_reg;
    assign centre_col = out_col_reg;
    assign channel    = out_chan_reg;
    assign magnitude  = out_mag_reg;
    assign frame_last = out_last_reg;
    assign empty      = !out_valid_reg;

    `ASSERT_PROP(a_root_ends, clk, rst_n, (state_reg == S_ROOT && bit_reg[0]) |=> (state_reg == S_FINISH), "square root did not finish after last step")
    `ASSERT_PROP(a_root_range, clk, rst_n, (state_reg == S_FINISH && !sat_reg) |-> (res_reg[15:8] == 8'd0), "unsaturated root above 8 bits")
    `ASSERT_PROP(a_load_from_finish, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FINISH), "result register loaded outside finish")

endmodule

`default_nettype wire

// File: src/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster stream of 8-bit interleaved channel samples.
// The front end takes one sample per clock while its job queue has room: the sample
// address is read from both line stores in the accept cycle and written back in the next
// cycle, so the line stores never stall a burst. Each interior result then goes through
// the magnitude unit (gradient, squares, sum, an 8-step bit-serial square root and
// rounding), which takes a new job only after finishing the last; the 4-entry job queue
// and the result register absorb bursts, and border samples (which give no result) pass at
// one per clock while the queue has room. Results appear in order with row, column, channel
// and an end-of-frame flag. A register write restarts the frame position; line stores need
// no clearing after reset. Depends on sem_pkg, sem_queue, sem_front and sem_back.
`default_nettype none

module sobel_edge_magnitude import sem_pkg::*; #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [ROW_OUT_W-1:0] centre_row,
    output logic [COL_OUT_W-1:0] centre_col,
    output logic [CH_OUT_W-1:0]  channel,
    output logic [7:0]           magnitude,
    output logic                 frame_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CFG_W-1:0]   image_width_reg;
    logic [CFG_W-1:0]   image_height_reg;
    logic [CHCFG_W-1:0] channel_count_reg;

    logic               cfg_write;
    logic               restart;
    logic [13:0]        w_clamped;
    logic [13:0]        h_clamped;
    logic [CHCFG_W-1:0] nc_clamped;
    logic [XW-1:0]      w_last;
    logic [RW-1:0]      h_last;
    logic [CW-1:0]      nc_last;

    logic               q_push;
    job_t               q_push_data;
    logic               q_pop;
    job_t               q_pop_data;
    logic               q_empty;
    logic [LEVEL_W-1:0] q_level;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= WIDTH_RESET;
            image_height_reg  <= HEIGHT_RESET;
            channel_count_reg <= CHANNELS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[CFG_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHCFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        restart = 1'b0;
        prdata  = '0;
        case (paddr[3:2])
            REG_IMAGE_WIDTH:
            begin
                restart = cfg_write;
                prdata  = 32'(image_width_reg);
            end
            REG_IMAGE_HEIGHT:
            begin
                restart = cfg_write;
                prdata  = 32'(image_height_reg);
            end
            REG_CHANNEL_COUNT:
            begin
                restart = cfg_write;
                prdata  = 32'(channel_count_reg);
            end
            default:
            begin
            end
        endcase
    end

    // registers keep any value; the frame geometry uses them clamped
    always_comb
    begin
        w_clamped  = 14'(image_width_reg);
        h_clamped  = 14'(image_height_reg);
        nc_clamped = channel_count_reg;
        if (w_clamped < 14'd3)
        begin
            w_clamped = 14'd3;
        end
        else if (w_clamped > 14'(MAX_WIDTH))
        begin
            w_clamped = 14'(MAX_WIDTH);
        end
        if (h_clamped < 14'd3)
        begin
            h_clamped = 14'd3;
        end
        else if (h_clamped > 14'(MAX_HEIGHT))
        begin
            h_clamped = 14'(MAX_HEIGHT);
        end
        if (nc_clamped < 3'd1)
        begin
            nc_clamped = 3'd1;
        end
        else if (nc_clamped > CHCFG_W'(MAX_CHANNELS))
        begin
            nc_clamped = CHCFG_W'(MAX_CHANNELS);
        end
        w_last  = XW'(w_clamped - 14'd1);
        h_last  = RW'(h_clamped - 14'd1);
        nc_last = CW'(nc_clamped - 3'd1);
    end

    sem_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .w_last  (w_last),
        .h_last  (h_last),
        .nc_last (nc_last),
        .push    (push),
        .sample  (sample),
        .full    (full),
        .q_level (q_level),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    sem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .level     (q_level)
    );

    sem_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .centre_row (centre_row),
        .centre_col (centre_col),
        .channel    (channel),
        .magnitude  (magnitude),
        .frame_last (frame_last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

// File: verif/sobel_edge_magnitude_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sobel_edge_magnitude: raster samples in, gradient results out
// depends on sem_pkg and the sobel_edge_magnitude rtl; results checked against a local predictor
module sobel_edge_magnitude_tb;
    import sem_pkg::*;

    localparam int LIMIT_W        = 2048;
    localparam int LIMIT_H        = 2048;
    localparam int LIMIT_CH       = 4;
    localparam int STORE_WORDS    = LIMIT_W * LIMIT_CH;
    localparam int MAG_TOP        = 255;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 850;
    localparam int RANDOM_RESULTS = 48;
    localparam int DIRECTED_ROWS  = 27;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CH_OUT_W-1:0]  chan;
        logic [7:0]           mag;
        logic                 last;
    } edge_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        edge_result_t        want;
    } stim_row_t;

    localparam edge_result_t NO_RESULT = '0;
    // hard step from 0 to 255 across the frame: saturates
    localparam edge_result_t STEP_WANT = '{row: 1, col: 1, chan: 0, mag: 255, last: 1};
    // bottom row at 3, rest at 0: gy = 12, gx = 0
    localparam edge_result_t RAMP_WANT = '{row: 1, col: 1, chan: 0, mag: 12, last: 1};

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 push;
    logic                 full;
    logic [SAMPLE_W-1:0]  sample;
    logic                 empty;
    logic                 pop;
    logic [ROW_OUT_W-1:0] centre_row;
    logic [COL_OUT_W-1:0] centre_col;
    logic [CH_OUT_W-1:0]  channel;
    logic [7:0]           magnitude;
    logic                 frame_last;

    // predictor state
    logic [11:0]         width_reg;
    logic [11:0]         height_reg;
    logic [2:0]          chans_reg;
    logic [7:0]          upper_line [STORE_WORDS];
    logic [7:0]          middle_line [STORE_WORDS];
    logic [7:0]          win_cols [LIMIT_CH][3][3];
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         chan_pos;

    edge_result_t        expected_results [$];
    int unsigned         mismatch_count;
    int unsigned         items_sent;
    int unsigned         results_predicted;
    bit                  push_on;
    int unsigned         burst_left;

    sobel_edge_magnitude dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .empty      (empty),
        .pop        (pop),
        .centre_row (centre_row),
        .centre_col (centre_col),
        .channel    (channel),
        .magnitude  (magnitude),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void flag_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void predict_gradient(input logic [SAMPLE_W-1:0] s,
                                             output bit produced, output edge_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned nc;
        int unsigned x;
        int unsigned r;
        int unsigned c;
        int unsigned addr;
        int unsigned k;
        logic [7:0]  top;
        logic [7:0]  mid;
        int          gx;
        int          gy;
        int          sq;
        int          m;
        w  = clamp_to(width_reg, 3, LIMIT_W);
        h  = clamp_to(height_reg, 3, LIMIT_H);
        nc = clamp_to(chans_reg, 1, LIMIT_CH);
        x  = col_pos;
        r  = row_pos;
        c  = chan_pos;

        addr = x * nc + c;
        top  = upper_line[addr];
        mid  = middle_line[addr];
        upper_line[addr]  = mid;
        middle_line[addr] = s;

        for (k = 0; k < 3; k++)
        begin
            win_cols[c][0][k] = win_cols[c][1][k];
            win_cols[c][1][k] = win_cols[c][2][k];
        end
        win_cols[c][2][0] = top;
        win_cols[c][2][1] = mid;
        win_cols[c][2][2] = s;

        produced = (r >= 2) && (x >= 2);
        res = NO_RESULT;
        if (produced)
        begin
            gx = (int'(win_cols[c][2][0]) + 2 * int'(win_cols[c][2][1]) + int'(win_cols[c][2][2]))
               - (int'(win_cols[c][0][0]) + 2 * int'(win_cols[c][0][1]) + int'(win_cols[c][0][2]));
            gy = (int'(win_cols[c][0][2]) + 2 * int'(win_cols[c][1][2]) + int'(win_cols[c][2][2]))
               - (int'(win_cols[c][0][0]) + 2 * int'(win_cols[c][1][0]) + int'(win_cols[c][2][0]));
            sq = gx * gx + gy * gy;
            // above 255.5 squared the rounded root is 256 or more
            if (sq > MAG_TOP * (MAG_TOP + 1))
                m = MAG_TOP;
            else
            begin
                m = 0;
                while ((m + 1) * (m + 1) <= sq)
                    m++;
                if (sq > m * m + m)
                    m++;
            end
            res.row  = ROW_OUT_W'(r - 1);
            res.col  = COL_OUT_W'(x - 1);
            res.chan = CH_OUT_W'(c);
            res.mag  = 8'(m);
            res.last = (r == h - 1) && (x == w - 1) && (c == nc - 1);
            results_predicted++;
        end

        c++;
        if (c >= nc)
        begin
            c = 0;
            x++;
            if (x >= w)
            begin
                x = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
        end
        col_pos  = x;
        row_pos  = r;
        chan_pos = c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned mode,
                                                        input int unsigned lo,
                                                        input int unsigned dev);
        case (mode)
            0:       return SAMPLE_W'($urandom_range(0, 255));
            1:       return SAMPLE_W'(lo + $urandom_range(0, dev));
            default: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        endcase
    endfunction

    task automatic wait_drained();
        if (push_on)
        begin
            push    <= 1'b0;
            push_on  = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input edge_result_t typed_want);
        bit           produced;
        edge_result_t res;
        int unsigned  gap;
        sample <= value;
        if (!push_on)
        begin
            push    <= 1'b1;
            push_on  = 1'b1;
        end
        do
            @(posedge clk);
        while (full);
        predict_gradient(value, produced, res);
        if (produced)
            expected_results.push_back(typed ? typed_want : res);
        items_sent++;

        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
            begin
                push    <= 1'b0;
                push_on  = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:   width_reg  = value[11:0];
            REG_IMAGE_HEIGHT:  height_reg = value[11:0];
            REG_CHANNEL_COUNT: chans_reg  = value[2:0];
            default: ;
        endcase
        // a write to any of the three registers restarts the frame
        col_pos  = 0;
        row_pos  = 0;
        chan_pos = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [11:0] w, input logic [11:0] h, input logic [2:0] nc);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 32'(w));
        write_reg(REG_IMAGE_HEIGHT, 32'(h));
        write_reg(REG_CHANNEL_COUNT, 32'(nc));
        read_reg(REG_IMAGE_WIDTH, 32'(w));
        read_reg(REG_IMAGE_HEIGHT, 32'(h));
        read_reg(REG_CHANNEL_COUNT, 32'(nc));
    endtask

    task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input logic [2:0] nc,
                             input int unsigned n, input bit mid_pause);
        int unsigned mode;
        int unsigned lo;
        int unsigned dev;
        int unsigned i;
        set_frame(w, h, nc);
        mode = $urandom_range(0, 2);
        lo   = $urandom_range(0, 235);
        dev  = $urandom_range(0, 20);
        for (i = 0; i < n; i++)
        begin
            // hold off until the block has handed back everything
            if (mid_pause && i == n / 2)
                wait_drained();
            send_sample(pick_sample(mode, lo, dev), 1'b0, NO_RESULT);
        end
    endtask

    // result side: checks each transfer, stalls on its own schedule
    initial
    begin : result_sink
        int unsigned  rx_phase;
        int unsigned  rx_period;
        int unsigned  rx_hold;
        int unsigned  rx_left;
        edge_result_t got;
        edge_result_t want;
        pop       = 1'b0;
        rx_phase  = 0;
        rx_period = 1;
        rx_hold   = 0;
        rx_left   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got = {centre_row, centre_col, channel, magnitude, frame_last};
                if (expected_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result row %0d col %0d ch %0d mag %0d",
                                            got.row, got.col, got.chan, got.mag));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.row !== want.row || got.col !== want.col || got.chan !== want.chan
                        || got.mag !== want.mag || got.last !== want.last)
                        flag_mismatch($sformatf(
                            "want r%0d c%0d ch%0d mag %0d last %0d, got r%0d c%0d ch%0d mag %0d last %0d",
                            want.row, want.col, want.chan, want.mag, want.last,
                            got.row, got.col, got.chan, got.mag, got.last));
                end
            end
            if (rx_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        rx_period = 1;
                        rx_hold   = 0;
                    end
                    1:
                    begin
                        rx_period = $urandom_range(2, 6);
                        rx_hold   = $urandom_range(1, rx_period - 1);
                    end
                    2:
                    begin
                        rx_period = $urandom_range(10, 30);
                        rx_hold   = rx_period - $urandom_range(1, 3);
                    end
                    default:
                    begin
                        rx_period = $urandom_range(3, 9);
                        rx_hold   = 1;
                    end
                endcase
                rx_left = $urandom_range(50, 400);
            end
            rx_left--;
            rx_phase++;
            pop <= (rx_phase % rx_period) >= rx_hold;
        end
    end

    initial
    begin : stimulus
        stim_row_t   directed [DIRECTED_ROWS];
        int unsigned i;
        int unsigned phase_no;
        int unsigned base_items;
        int unsigned base_results;
        int unsigned frame_items;
        int unsigned row_items;
        int unsigned n;
        logic [11:0] w_val;
        logic [11:0] h_val;
        logic [2:0]  nc_val;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        push    = 1'b0;
        sample  = '0;

        push_on           = 1'b0;
        burst_left        = 0;
        mismatch_count    = 0;
        items_sent        = 0;
        results_predicted = 0;
        width_reg         = WIDTH_RESET;
        height_reg        = HEIGHT_RESET;
        chans_reg         = CHANNELS_RESET;
        col_pos           = 0;
        row_pos           = 0;
        chan_pos          = 0;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (win_cols[a, b, d])
            win_cols[a][b][d] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_reg(REG_IMAGE_WIDTH, 32'(WIDTH_RESET));
        read_reg(REG_IMAGE_HEIGHT, 32'(HEIGHT_RESET));
        read_reg(REG_CHANNEL_COUNT, 32'(CHANNELS_RESET));

        // three 3x3 frames: a hard step, a gentle ramp, mixed values
        directed = '{
            '{8'd0,   1'b0, NO_RESULT}, '{8'd128, 1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd128, 1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd128, 1'b0, NO_RESULT}, '{8'd255, 1'b1, STEP_WANT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT},
            '{8'd3,   1'b0, NO_RESULT}, '{8'd3,   1'b0, NO_RESULT}, '{8'd3,   1'b1, RAMP_WANT},
            '{8'd10,  1'b0, NO_RESULT}, '{8'd200, 1'b0, NO_RESULT}, '{8'd37,  1'b0, NO_RESULT},
            '{8'd90,  1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT},
            '{8'd1,   1'b0, NO_RESULT}, '{8'd254, 1'b0, NO_RESULT}, '{8'd128, 1'b0, NO_RESULT}
        };
        set_frame(12'd3, 12'd3, 3'd1);
        foreach (directed[i])
            send_sample(directed[i].value, directed[i].typed, directed[i].want);

        // small random frames, with sizes below range and broken frames mixed in
        phase_no     = 0;
        base_items   = items_sent;
        base_results = results_predicted;
        while (items_sent - base_items < RANDOM_ITEMS
               || results_predicted - base_results < RANDOM_RESULTS)
        begin
            w_val  = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                                 : 12'($urandom_range(3, 12));
            h_val  = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                                 : 12'($urandom_range(3, 8));
            nc_val = 3'($urandom_range(0, 7));
            row_items   = clamp_to(w_val, 3, LIMIT_W) * clamp_to(nc_val, 1, LIMIT_CH);
            frame_items = row_items * clamp_to(h_val, 3, LIMIT_H);
            n = frame_items * ((frame_items > 150) ? 1 : $urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n + row_items);
            run_phase(w_val, h_val, nc_val, n, (phase_no == 1) || ($urandom_range(0, 5) == 0));
            phase_no++;
        end

        // widest rows and every store address; register values above range clamp
        run_phase(12'hfff, 12'd3, 3'd7, LIMIT_W * 3 * LIMIT_CH, 1'b0);
        // tallest frame
        run_phase(12'd3, 12'hfff, 3'd1, 3 * LIMIT_H, 1'b0);
        // exact upper limits, first rows only
        run_phase(12'(LIMIT_W), 12'(LIMIT_H), 3'(LIMIT_CH), 2 * LIMIT_W * LIMIT_CH + 64, 1'b0);
        // back to the power-on frame size
        run_phase(WIDTH_RESET, HEIGHT_RESET, CHANNELS_RESET, 2 * int'(WIDTH_RESET) + 64, 1'b0);

        wait_drained();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
